FILE: hdl/transposition_table_probe_store_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the transposition table probe store.
// Each macro expects clk and rst_n to be visible where it is used.
// ---------------------------------------------------------------------------
`ifndef TRANSPOSITION_TABLE_PROBE_STORE_DEFINES_SVH
`define TRANSPOSITION_TABLE_PROBE_STORE_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define TTPS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// consequent checked in the cycle after the antecedent
`define TTPS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hdl/ttps_pkg.sv
// ---------------------------------------------------------------------------
// ttps_pkg
// Types, constants and helpers shared by the probe store modules.
// ---------------------------------------------------------------------------
package ttps_pkg;

    localparam int unsigned TTPS_MAX_CLUSTERS = 1024;
    localparam int unsigned TTPS_WAYS         = 3;

    localparam int unsigned CC_W       = 11;
    localparam int unsigned CFG_DATA_W = 11;
    localparam int unsigned CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_GEN    = 1'b1;

    localparam logic [CC_W-1:0] CLUSTER_COUNT_RESET = 11'd1024;
    localparam logic [7:0]      SEARCH_GEN_RESET    = 8'd0;

    localparam logic       ACT_PROBE   = 1'b0;
    localparam logic       ACT_WRITE   = 1'b1;
    localparam logic [1:0] EXACT_BOUND = 2'd3;
    localparam logic [7:0] AGE_MASK    = 8'hF8;
    localparam logic [7:0] AGE_OFFSET  = 8'd7;   // 263 taken modulo 256
    localparam logic [8:0] DEPTH_SLACK = 9'd2;

    // depth minus twice the age, range -496 .. 255
    localparam int unsigned SCORE_W = 11;

    typedef struct packed {
        logic              action;
        logic [63:0]       key;
        logic signed [15:0] new_value;
        logic signed [15:0] new_eval;
        logic [15:0]       new_move;
        logic [7:0]        new_depth;
        logic [1:0]        new_bound;
        logic              new_pv;
    } ttps_req_t;

    typedef struct packed {
        logic              found;
        logic [15:0]       hit_move;
        logic signed [15:0] hit_value;
        logic signed [15:0] hit_eval;
        logic [7:0]        hit_depth;
        logic [1:0]        hit_bound;
        logic              hit_pv;
    } ttps_rsp_t;

    typedef struct packed {
        logic [15:0]        tag;
        logic [7:0]         depth;
        logic [7:0]         genbound;
        logic [15:0]        move;
        logic signed [15:0] value;
        logic signed [15:0] eval;
    } ttps_entry_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_READ,
        ST_RESOLVE,
        ST_WREAD,
        ST_WMERGE
    } ttps_state_t;

    typedef struct packed {
        logic ready;
        logic load_req;
        logic mul_en;
        logic rd_probe;
        logic rd_slot;
        logic resolve;
        logic write_back;
        logic clr_wr;
    } ttps_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic req_write;
        logic out_free;
    } ttps_status_t;

    function automatic logic [7:0] ttps_age(input logic [7:0] gen, input logic [7:0] gb);
        logic [7:0] diff;
        diff = gen + AGE_OFFSET - gb;
        return diff & AGE_MASK;
    endfunction

endpackage

FILE: hdl/ttps_ctrl.sv
// ---------------------------------------------------------------------------
// ttps_ctrl
// Sequencer for the probe store: clearing pass, probe and write sequences.
// ---------------------------------------------------------------------------
module ttps_ctrl
    import ttps_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         req_valid,
    input  ttps_status_t status,
    output ttps_cmd_t    cmd
);

    ttps_state_t state_reg;
    ttps_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (status.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = status.req_write ? ST_WREAD : ST_MUL;
                end
            end
            ST_MUL:     state_next = ST_READ;
            ST_READ:    state_next = ST_RESOLVE;
            ST_RESOLVE:
            begin
                // hold until the output register can take the result
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_WREAD:   state_next = ST_WMERGE;
            ST_WMERGE:  state_next = ST_IDLE;
            default:    state_next = ST_CLEAR;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_CLEAR:   cmd.clr_wr = 1'b1;
            ST_IDLE:
            begin
                cmd.ready    = 1'b1;
                cmd.load_req = req_valid;
            end
            ST_MUL:     cmd.mul_en = 1'b1;
            ST_READ:    cmd.rd_probe = 1'b1;
            ST_RESOLVE: cmd.resolve = status.out_free;
            ST_WREAD:   cmd.rd_slot = 1'b1;
            ST_WMERGE:  cmd.write_back = 1'b1;
            default:    cmd = '0;
        endcase
    end

endmodule

FILE: hdl/ttps_datapath.sv
// ---------------------------------------------------------------------------
// ttps_datapath
// Cluster memory, key-to-cluster multiply, tag match, victim choice and merge.
// ---------------------------------------------------------------------------
module ttps_datapath
    import ttps_pkg::*;
#(
    parameter int unsigned MAX_CLUSTERS = TTPS_MAX_CLUSTERS,
    parameter int unsigned WAYS         = TTPS_WAYS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ttps_req_t             req,
    input  logic                  rsp_stall,
    output logic                  rsp_valid,
    output ttps_rsp_t             rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  ttps_cmd_t             cmd,
    output ttps_status_t          status
);

    localparam int unsigned CIDX_W = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int unsigned WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int unsigned PROD_W = 32 + CC_W;
    localparam int unsigned CC_CAP = (MAX_CLUSTERS < 2047) ? MAX_CLUSTERS : 2047;

    // configuration
    logic [CC_W-1:0] cluster_count_reg;
    logic [7:0]      search_gen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cluster_count_reg <= CLUSTER_COUNT_RESET;
            search_gen_reg    <= SEARCH_GEN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CLUSTER_COUNT: cluster_count_reg <= cfg_data[CC_W-1:0];
                CFG_SEARCH_GEN:    search_gen_reg    <= cfg_data[7:0];
                default:           search_gen_reg    <= search_gen_reg;
            endcase
        end
    end

    // request capture
    ttps_req_t req_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg <= req;
        end
    end

    // key times cluster count, split into two 32-bit halves
    logic [CC_W-1:0]   cc_sat;
    logic [PROD_W-1:0] prod_lo_reg;
    logic [PROD_W-1:0] prod_hi_reg;
    logic [PROD_W-1:0] prod_sum;
    logic [CC_W-1:0]   probe_idx;
    logic [CIDX_W-1:0] probe_addr;

    assign cc_sat = (cluster_count_reg > CC_W'(CC_CAP)) ? CC_W'(CC_CAP) : cluster_count_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_lo_reg <= {{CC_W{1'b0}}, req_reg.key[31:0]} * {32'b0, cc_sat};
            prod_hi_reg <= {{CC_W{1'b0}}, req_reg.key[63:32]} * {32'b0, cc_sat};
        end
    end

    assign prod_sum   = prod_hi_reg + PROD_W'(prod_lo_reg[PROD_W-1:32]);
    assign probe_idx  = prod_sum[PROD_W-1:32];
    assign probe_addr = CIDX_W'(probe_idx);

    // clearing pass counter
    logic [CIDX_W-1:0] clr_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr_wr)
        begin
            clr_cnt_reg <= clr_cnt_reg + CIDX_W'(1);
        end
    end

    // remembered slot
    logic [CIDX_W-1:0] chosen_cluster_reg;
    logic [WAY_W-1:0]  chosen_way_reg;
    logic [CIDX_W-1:0] probe_cluster_reg;

    // cluster memory, one row of WAYS entries per cluster
    ttps_entry_t [WAYS-1:0] entry_mem [MAX_CLUSTERS];
    ttps_entry_t [WAYS-1:0] rd_row_reg;
    ttps_entry_t [WAYS-1:0] merged_row;
    logic [CIDX_W-1:0]      rd_addr;
    logic [CIDX_W-1:0]      wr_addr;
    logic                   mem_we;

    assign rd_addr = cmd.rd_probe ? probe_addr : chosen_cluster_reg;
    assign wr_addr = cmd.clr_wr ? clr_cnt_reg : chosen_cluster_reg;
    assign mem_we  = cmd.clr_wr | cmd.write_back;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[wr_addr] <= cmd.clr_wr ? '0 : merged_row;
        end
        if (cmd.rd_probe | cmd.rd_slot)
        begin
            rd_row_reg <= entry_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_probe)
        begin
            probe_cluster_reg <= probe_addr;
        end
    end

    // tag match and victim choice
    logic                      hit;
    logic [WAY_W-1:0]          hit_way;
    logic [WAY_W-1:0]          pick_way;
    logic signed [SCORE_W-1:0] score [WAYS];
    logic signed [SCORE_W-1:0] best;
    ttps_entry_t               hit_entry;
    ttps_rsp_t                 rsp_next;

    always_comb
    begin
        hit     = 1'b0;
        hit_way = '0;
        // walk downwards so the earliest matching way wins
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (rd_row_reg[w].tag == req_reg.key[15:0])
            begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
        end
    end

    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            score[w] = $signed({3'b0, rd_row_reg[w].depth})
                     - $signed({2'b0, ttps_age(search_gen_reg, rd_row_reg[w].genbound), 1'b0});
        end
        best     = score[0];
        pick_way = '0;
        for (int w = 1; w < WAYS; w++)
        begin
            if (best > score[w])
            begin
                best     = score[w];
                pick_way = WAY_W'(w);
            end
        end
    end

    always_comb
    begin
        hit_entry = rd_row_reg[hit_way];
        rsp_next  = '0;
        if (hit)
        begin
            rsp_next.found     = (hit_entry.depth != 8'd0);
            rsp_next.hit_move  = hit_entry.move;
            rsp_next.hit_value = hit_entry.value;
            rsp_next.hit_eval  = hit_entry.eval;
            rsp_next.hit_depth = hit_entry.depth;
            rsp_next.hit_bound = hit_entry.genbound[1:0];
            rsp_next.hit_pv    = hit_entry.genbound[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chosen_cluster_reg <= '0;
            chosen_way_reg     <= '0;
        end
        else if (cmd.resolve)
        begin
            chosen_cluster_reg <= probe_cluster_reg;
            chosen_way_reg     <= hit ? hit_way : pick_way;
        end
    end

    // depth/age replacement merge into the remembered way
    ttps_entry_t old_entry;
    ttps_entry_t new_entry;
    logic        tag_differs;
    logic        replace_data;

    always_comb
    begin
        old_entry    = rd_row_reg[chosen_way_reg];
        new_entry    = old_entry;
        tag_differs  = (req_reg.key[15:0] != old_entry.tag);
        replace_data = (req_reg.new_bound == EXACT_BOUND) || tag_differs
                    || (({1'b0, req_reg.new_depth} + DEPTH_SLACK) >= {1'b0, old_entry.depth})
                    || (ttps_age(search_gen_reg, old_entry.genbound) != 8'd0);
        if ((req_reg.new_move != 16'd0) || tag_differs)
        begin
            new_entry.move = req_reg.new_move;
        end
        if (replace_data)
        begin
            new_entry.tag      = req_reg.key[15:0];
            new_entry.depth    = req_reg.new_depth;
            new_entry.genbound = search_gen_reg | {5'b0, req_reg.new_pv, req_reg.new_bound};
            new_entry.value    = req_reg.new_value;
            new_entry.eval     = req_reg.new_eval;
        end
        merged_row                 = rd_row_reg;
        merged_row[chosen_way_reg] = new_entry;
    end

    // output register
    logic      rsp_valid_reg;
    ttps_rsp_t rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.resolve)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.resolve)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign status.clr_last  = (clr_cnt_reg == CIDX_W'(MAX_CLUSTERS - 1));
    assign status.req_write = (req.action == ACT_WRITE);
    assign status.out_free  = !rsp_valid_reg || !rsp_stall;

endmodule

FILE: hdl/transposition_table_probe_store.sv
// ---------------------------------------------------------------------------
// transposition_table_probe_store
// Set-associative search entry table with depth/age replacement.
// ---------------------------------------------------------------------------
// Requests arrive on req (valid/stall). A probe (action 0) looks up the
// cluster chosen by key and returns one result on rsp; a write (action 1)
// updates the slot remembered by the last probe and returns nothing.
// Configuration writes on cfg_we/cfg_index/cfg_data take effect at once;
// the user must make them only while the block is idle, which the block
// itself does not enforce. A probe steps through accept, split key
// multiply, cluster row read, then match/victim choice into the output
// register; the result is visible the cycle after that. A write steps
// through accept, row read, merge and write back. One request is in flight
// at a time, set by the sequencer, which accepts only in its idle state.
// After reset a clearing pass zeroes the table, one cluster row per cycle;
// req_stall stays high until it ends.
// While rsp_stall holds a result, a new request is still accepted; a probe
// then waits in its last step until the output register is free.
// ---------------------------------------------------------------------------
module transposition_table_probe_store
    import ttps_pkg::*;
#(
    parameter int unsigned MAX_CLUSTERS = TTPS_MAX_CLUSTERS,
    parameter int unsigned WAYS         = TTPS_WAYS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  ttps_req_t             req,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output ttps_rsp_t             rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    ttps_cmd_t    cmd;
    ttps_status_t status;

    ttps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .status    (status),
        .cmd       (cmd)
    );

    ttps_datapath #(
        .MAX_CLUSTERS (MAX_CLUSTERS),
        .WAYS         (WAYS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

    assign req_stall = !cmd.ready;

endmodule

FILE: hdl/ttps_checker.sv
// ---------------------------------------------------------------------------
// ttps_checker
// Port-level checks on the probe store, bound to the top level.
// ---------------------------------------------------------------------------
`include "transposition_table_probe_store_defines.svh"

module ttps_checker
    import ttps_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      req_valid,
    input logic      req_stall,
    input ttps_req_t req,
    input logic      rsp_valid,
    input logic      rsp_stall,
    input ttps_rsp_t rsp
);

    // a stalled result holds
    `TTPS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

    // one request in flight: an accepted request closes the input
    `TTPS_ASSERT_NEXT(a_one_in_flight, req_valid && !req_stall, req_stall)

    // a write never raises a result
    `TTPS_ASSERT_NEXT(a_write_silent,
        req_valid && !req_stall && (req.action == ACT_WRITE) && !rsp_valid, !rsp_valid)

    // a result only appears while a probe is being worked on
    `TTPS_ASSERT_NOW(a_rsp_from_probe, $rose(rsp_valid), $past(req_stall))

    // an occupied hit always carries a nonzero depth
    `TTPS_ASSERT_NOW(a_found_depth, rsp_valid && rsp.found, rsp.hit_depth != 8'd0)

endmodule

bind transposition_table_probe_store ttps_checker u_checker (.*);

FILE: test/transposition_table_probe_store_test.sv
// ---------------------------------------------------------------------------
// transposition_table_probe_store_test
// Self-checking bench for the probe store. A clocked driver feeds requests
// and register writes from a queue; a clocked monitor mirrors the table,
// predicts each probe result and compares it field by field with the
// block's output. Both handshakes idle at random.
// ---------------------------------------------------------------------------
module transposition_table_probe_store_test
    import ttps_pkg::*;
();

    localparam int unsigned SLOT_COUNT    = TTPS_MAX_CLUSTERS * TTPS_WAYS;
    localparam int          PHASE_ITEMS   = 160;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          DRAIN_CYCLES  = 16;
    localparam int          CYCLE_LIMIT   = 800000;

    typedef struct {
        logic                  is_cfg;
        logic [CFG_IDX_W-1:0]  cfg_idx;
        logic [CFG_DATA_W-1:0] cfg_val;
        ttps_req_t             item;
    } queued_op_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_stall;
    ttps_req_t             req       = '0;
    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    ttps_rsp_t             rsp;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_CLUSTER_COUNT;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // mirror of the block's state and registers
    ttps_entry_t     slot_mirror [SLOT_COUNT];
    int unsigned     remembered_slot;
    logic [CC_W-1:0] mirror_clusters;
    logic [7:0]      mirror_gen;

    ttps_rsp_t  probe_results [$];
    queued_op_t issue_queue [$];
    logic [31:0] hi_pool [6];
    logic [15:0] tag_pool [10];

    logic req_taken   = 1'b0;
    int   idle_count  = 0;
    int   gap_left    = 0;
    int   stall_left  = 0;
    int   cycle_count = 0;
    int   fail_count  = 0;

    transposition_table_probe_store i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ---------------- prediction ----------------

    function automatic int unsigned cluster_base(logic [63:0] key);
        logic [63:0] cc;
        logic [63:0] idx;
        cc = (mirror_clusters > TTPS_MAX_CLUSTERS) ? 64'(TTPS_MAX_CLUSTERS)
                                                   : 64'(mirror_clusters);
        idx = (64'(key[63:32]) * cc + ((64'(key[31:0]) * cc) >> 32)) >> 32;
        if (idx >= TTPS_MAX_CLUSTERS)
            idx = 64'(TTPS_MAX_CLUSTERS - 1);
        return int'(idx) * TTPS_WAYS;
    endfunction

    function automatic logic [7:0] gen_age(logic [7:0] genbound);
        logic [7:0] diff;
        diff = mirror_gen + AGE_OFFSET - genbound;
        return diff & AGE_MASK;
    endfunction

    function automatic int victim_score(ttps_entry_t e);
        return int'(e.depth) - 2 * int'(gen_age(e.genbound));
    endfunction

    task automatic store_entry(ttps_req_t r);
        ttps_entry_t e;
        logic        differs;
        e = slot_mirror[remembered_slot];
        differs = (r.key[15:0] != e.tag);
        if (r.new_move != 16'd0 || differs)
            e.move = r.new_move;
        if (r.new_bound == EXACT_BOUND || differs
            || ({1'b0, r.new_depth} + DEPTH_SLACK >= {1'b0, e.depth})
            || gen_age(e.genbound) != 8'd0)
        begin
            e.tag      = r.key[15:0];
            e.depth    = r.new_depth;
            e.genbound = mirror_gen | {5'd0, r.new_pv, 2'd0} | {6'd0, r.new_bound};
            e.value    = r.new_value;
            e.eval     = r.new_eval;
        end
        slot_mirror[remembered_slot] = e;
    endtask

    task automatic probe_entry(logic [63:0] key);
        int unsigned base;
        int unsigned pick;
        int          best;
        int          score;
        ttps_entry_t e;
        ttps_rsp_t   res;
        base = cluster_base(key);
        res  = '0;
        for (int w = 0; w < TTPS_WAYS; w++)
        begin
            e = slot_mirror[base + w];
            if (e.tag == key[15:0])
            begin
                remembered_slot = base + w;
                res.found     = (e.depth != 8'd0);
                res.hit_move  = e.move;
                res.hit_value = e.value;
                res.hit_eval  = e.eval;
                res.hit_depth = e.depth;
                res.hit_bound = e.genbound[1:0];
                res.hit_pv    = e.genbound[2];
                probe_results.push_back(res);
                return;
            end
        end
        // miss: earliest way wins a tie
        pick = 0;
        best = victim_score(slot_mirror[base]);
        for (int w = 1; w < TTPS_WAYS; w++)
        begin
            score = victim_score(slot_mirror[base + w]);
            if (best > score)
            begin
                best = score;
                pick = w;
            end
        end
        remembered_slot = base + pick;
        probe_results.push_back(res);
    endtask

    task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    // ---------------- monitor ----------------

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            req_taken <= req_valid && !req_stall;
            if (cfg_we)
            begin
                if (cfg_index == CFG_CLUSTER_COUNT)
                    mirror_clusters = cfg_data;
                else if (cfg_index == CFG_SEARCH_GEN)
                    mirror_gen = cfg_data[7:0];
            end
            if (req_valid && !req_stall)
            begin
                if (req.action == ACT_WRITE)
                    store_entry(req);
                else
                    probe_entry(req.key);
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (probe_results.size() == 0)
                begin
                    $error("result with no probe outstanding");
                    fail_count++;
                end
                else
                begin
                    ttps_rsp_t want;
                    want = probe_results.pop_front();
                    compare_field("found", 16'(want.found), 16'(rsp.found));
                    compare_field("hit_move", want.hit_move, rsp.hit_move);
                    compare_field("hit_value", want.hit_value, rsp.hit_value);
                    compare_field("hit_eval", want.hit_eval, rsp.hit_eval);
                    compare_field("hit_depth", 16'(want.hit_depth), 16'(rsp.hit_depth));
                    compare_field("hit_bound", 16'(want.hit_bound), 16'(rsp.hit_bound));
                    compare_field("hit_pv", 16'(want.hit_pv), 16'(rsp.hit_pv));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("transposition_table_probe_store_test NOT OK");
            $finish;
        end
    end

    // ---------------- driver ----------------

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // periodic stretches with no idling on either side
    function automatic logic calm_stretch();
        return ((cycle_count / 1500) % 4) == 1;
    endfunction

    always @(negedge clk)
    begin : drive_loop
        logic       next_valid;
        logic       next_we;
        queued_op_t op;
        if (rst_n)
        begin
            next_valid = req_valid && !req_taken;
            next_we    = 1'b0;
            if (!next_valid)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (issue_queue.size() > 0 && issue_queue[0].is_cfg)
                begin
                    // registers change only once the block has gone quiet
                    if (idle_count >= SETTLE_CYCLES && !req_stall)
                    begin
                        op = issue_queue.pop_front();
                        next_we = 1'b1;
                        cfg_index <= op.cfg_idx;
                        cfg_data  <= op.cfg_val;
                    end
                end
                else if (issue_queue.size() > 0)
                begin
                    op = issue_queue.pop_front();
                    req <= op.item;
                    next_valid = 1'b1;
                    gap_left = calm_stretch() ? 0 : pick_gap();
                end
            end
            req_valid <= next_valid;
            cfg_we    <= next_we;
            if (next_valid || probe_results.size() != 0)
                idle_count = 0;
            else
                idle_count++;

            if (stall_left > 0)
            begin
                rsp_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                rsp_stall <= 1'b0;
                if (!calm_stretch() && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // ---------------- stimulus ----------------

    task automatic queue_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        queued_op_t op;
        op.is_cfg  = 1'b1;
        op.cfg_idx = idx;
        op.cfg_val = val;
        op.item    = '0;
        issue_queue.push_back(op);
    endtask

    task automatic queue_request(ttps_req_t r);
        queued_op_t op;
        op.is_cfg  = 1'b0;
        op.cfg_idx = CFG_CLUSTER_COUNT;
        op.cfg_val = '0;
        op.item    = r;
        issue_queue.push_back(op);
    endtask

    function automatic ttps_req_t make_request(logic act, logic [63:0] key,
                                               logic [15:0] value, logic [15:0] eval,
                                               logic [15:0] move, logic [7:0] depth,
                                               logic [1:0] bound, logic pv);
        ttps_req_t r;
        r.action    = act;
        r.key       = key;
        r.new_value = value;
        r.new_eval  = eval;
        r.new_move  = move;
        r.new_depth = depth;
        r.new_bound = bound;
        r.new_pv    = pv;
        return r;
    endfunction

    function automatic ttps_req_t random_write(logic [63:0] key);
        ttps_req_t r;
        r.action    = ACT_WRITE;
        r.key       = key;
        r.new_value = 16'($urandom);
        r.new_eval  = 16'($urandom);
        r.new_move  = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
        r.new_depth = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 12))
                                                  : 8'($urandom);
        r.new_bound = 2'($urandom);
        r.new_pv    = 1'($urandom);
        return r;
    endfunction

    function automatic ttps_req_t random_probe(logic [63:0] key);
        ttps_req_t r;
        r = random_write(key);
        r.action = ACT_PROBE;
        return r;
    endfunction

    // keys drawn from small pools so that clusters collide and tags recur
    function automatic logic [63:0] pool_key();
        return {hi_pool[$urandom_range(0, 5)], 16'($urandom), tag_pool[$urandom_range(0, 9)]};
    endfunction

    task automatic queue_phase(logic [CC_W-1:0] clusters, logic [7:0] gen, int count);
        logic [63:0] key;
        int          n;
        int          r;
        queue_cfg(CFG_CLUSTER_COUNT, clusters);
        queue_cfg(CFG_SEARCH_GEN, CFG_DATA_W'(gen));
        n = 0;
        while (n < count)
        begin
            r = $urandom_range(0, 99);
            if (r < 75)
            begin
                // probe, then usually store into the slot it chose
                key = pool_key();
                queue_request(random_probe(key));
                n++;
                if ($urandom_range(0, 9) < 8)
                begin
                    if ($urandom_range(0, 9) == 0)
                        key[15:0] = tag_pool[$urandom_range(0, 9)];
                    queue_request(random_write(key));
                    n++;
                end
            end
            else if (r < 88)
            begin
                queue_request(random_probe({$urandom, $urandom}));
                n++;
            end
            else
            begin
                key = ($urandom_range(0, 1) == 0) ? pool_key() : {$urandom, $urandom};
                queue_request(random_write(key));
                n++;
            end
        end
    endtask

    initial
    begin
        for (int i = 0; i < SLOT_COUNT; i++)
            slot_mirror[i] = '0;
        remembered_slot = 0;
        mirror_clusters = CLUSTER_COUNT_RESET;
        mirror_gen      = SEARCH_GEN_RESET;

        hi_pool[0] = 32'h0000_0000;
        hi_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 6; i++)
            hi_pool[i] = $urandom;
        tag_pool[0] = 16'h0000;
        tag_pool[1] = 16'hFFFF;
        for (int i = 2; i < 10; i++)
            tag_pool[i] = 16'($urandom);

        queue_cfg(CFG_CLUSTER_COUNT, CLUSTER_COUNT_RESET);
        queue_cfg(CFG_SEARCH_GEN, CFG_DATA_W'(SEARCH_GEN_RESET));

        // store before any probe lands in slot 0
        queue_request(make_request(ACT_WRITE, 64'h1234, 16'h8000, 16'h7FFF, 16'hFFFF,
                                   8'd255, EXACT_BOUND, 1'b1));
        queue_request(make_request(ACT_PROBE, 64'h1234, '0, '0, '0, '0, '0, 1'b0));
        // shallow inexact store on the same tag keeps everything
        queue_request(make_request(ACT_WRITE, 64'h1234, 16'h0011, 16'h0022, 16'h0000,
                                   8'd1, 2'd0, 1'b0));
        queue_request(make_request(ACT_PROBE, 64'h1234, '0, '0, '0, '0, '0, 1'b0));
        // a nonzero move is taken on its own
        queue_request(make_request(ACT_WRITE, 64'h1234, 16'h0033, 16'h0044, 16'h0001,
                                   8'd1, 2'd0, 1'b0));
        queue_request(make_request(ACT_PROBE, 64'h1234, '0, '0, '0, '0, '0, 1'b0));
        // tag zero matches an empty way
        queue_request(make_request(ACT_PROBE, 64'h0, '0, '0, '0, '0, '0, 1'b0));
        queue_request(make_request(ACT_WRITE, 64'h0, 16'h0005, 16'hFFFB, 16'h00AA,
                                   8'd0, 2'd2, 1'b1));
        queue_request(make_request(ACT_PROBE, 64'h0, '0, '0, '0, '0, '0, 1'b0));
        // top cluster, all-ones tag
        queue_request(make_request(ACT_PROBE, '1, '1, '1, '1, '1, '1, 1'b1));
        queue_request(make_request(ACT_WRITE, '1, 16'h7FFF, 16'h8000, 16'h0000,
                                   8'd128, 2'd1, 1'b0));
        queue_request(make_request(ACT_PROBE, '1, '0, '0, '0, '0, '0, 1'b0));
        queue_request(make_request(ACT_PROBE, 64'hFFFF_FFFF_0000_0001, '0, '0, '0, '0, '0,
                                   1'b0));
        queue_request(make_request(ACT_WRITE, 64'hFFFF_FFFF_0000_0001, 16'h0100, 16'h0200,
                                   16'h0300, 8'd7, 2'd0, 1'b1));
        queue_request(make_request(ACT_PROBE, 64'hFFFF_FFFF_0000_0001, '0, '0, '0, '0, '0,
                                   1'b0));

        queue_phase(11'd1, 8'd8, PHASE_ITEMS);
        queue_phase(11'd3, 8'd16, PHASE_ITEMS);
        queue_phase(11'd1024, 8'd24, PHASE_ITEMS);
        queue_phase(11'd0, 8'd32, PHASE_ITEMS);
        queue_phase(11'd2047, 8'd248, PHASE_ITEMS);
        queue_phase(11'd2, 8'd255, PHASE_ITEMS);
        queue_phase(11'($urandom_range(1, 1024)), 8'd0, PHASE_ITEMS);
        queue_phase(11'd1024, 8'($urandom_range(0, 31) * 8), PHASE_ITEMS);
        queue_phase(11'd1, 8'd40, PHASE_ITEMS);
        queue_phase(11'($urandom_range(4, 64)), 8'd48, PHASE_ITEMS);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // drain: everything issued, every result in, then a quiet spell
        while (issue_queue.size() != 0 || idle_count < DRAIN_CYCLES)
            @(posedge clk);

        if (fail_count == 0)
            $display("transposition_table_probe_store_test OK");
        else
            $display("transposition_table_probe_store_test NOT OK");
        $finish;
    end

endmodule
